FILE: sv/udp_packet_filter_top_defines.svh
// ----------------------------------------------------------------------------
// udp_packet_filter_top_defines.svh
// Assertion macros shared by the packet filter checker.
// ----------------------------------------------------------------------------
`ifndef UDP_PACKET_FILTER_TOP_DEFINES_SVH
`define UDP_PACKET_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define UPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define UPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked around reset.
`define UPF_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/upf_pkg.sv
// ----------------------------------------------------------------------------
// upf_pkg
// Types and constants of the byte-serial UDP packet filter.
// ----------------------------------------------------------------------------
package upf_pkg;

  // Result actions.
  localparam logic [1:0] ACT_PASS     = 2'd0;
  localparam logic [1:0] ACT_DROP     = 2'd1;
  localparam logic [1:0] ACT_REDIRECT = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_PREFIX     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_MASK       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DROP_PORT         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IPV6_DEST_PREFIX  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOCKET_BOUND_MASK = 3'd4;
  localparam int unsigned CFG_DATA_W = 64;

  // Register reset values.
  localparam logic [31:0] RST_SOURCE_PREFIX    = 32'hB79C_2400;
  localparam logic [31:0] RST_SOURCE_MASK      = 32'hFFFF_FF00;
  localparam logic [15:0] RST_DROP_PORT        = 16'd12345;
  localparam logic [15:0] RST_IPV6_DEST_PREFIX = 16'hFD00;

  // Number of queue codes a 6-bit queue index can name.
  localparam int unsigned QUEUE_SPACE = 64;

  // Ether types and protocol numbers.
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETH_TYPE_QINQ = 16'h88A8;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;

  // Byte positions in the frame and offsets from the start of layer 3.
  localparam logic [7:0] ETH_TYPE_HI_POS = 8'd12;
  localparam logic [7:0] ETH_TYPE_LO_POS = 8'd13;
  localparam logic [7:0] ETH_HDR_LEN     = 8'd14;
  localparam logic [7:0] TAG_TYPE_HI_OFS = 8'd2;
  localparam logic [7:0] TAG_TYPE_LO_OFS = 8'd3;
  localparam logic [4:0] TAG_LEN         = 5'd4;
  localparam logic [7:0] IPV4_PROTO_OFS  = 8'd9;
  localparam logic [7:0] IPV4_SRC_FIRST  = 8'd12;
  localparam logic [7:0] IPV4_SRC_LAST   = 8'd15;
  localparam logic [7:0] IPV4_DPORT_HI   = 8'd22;
  localparam logic [7:0] IPV4_DPORT_LO   = 8'd23;
  localparam logic [7:0] IPV4_MIN_LEN    = 8'd28;
  localparam logic [7:0] IPV6_NEXT_OFS   = 8'd6;
  localparam logic [7:0] IPV6_DST_HI     = 8'd24;
  localparam logic [7:0] IPV6_DST_LO     = 8'd25;
  localparam logic [7:0] IPV6_DPORT_HI   = 8'd42;
  localparam logic [7:0] IPV6_DPORT_LO   = 8'd43;
  localparam logic [7:0] IPV6_MIN_LEN    = 8'd48;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] queue_index;
  } upf_in_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  out_queue;
    logic [31:0] last_source;
    logic [31:0] passed_count;
  } upf_out_t;

  // Match settings handed from the register file to the parser.
  typedef struct packed {
    logic [31:0] source_prefix;
    logic [31:0] source_mask;
    logic [15:0] drop_port;
    logic [15:0] ipv6_dest_prefix;
  } upf_match_t;

endpackage

FILE: sv/upf_cfg_regs.sv
// ----------------------------------------------------------------------------
// upf_cfg_regs
// Configuration register file of the packet filter.
// ----------------------------------------------------------------------------
module upf_cfg_regs
  import upf_pkg::*;
#(
  parameter int unsigned NUM_QUEUES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output upf_match_t             match,
  output logic [NUM_QUEUES-1:0]  socket_bound
);

  always_ff @(posedge clk) begin
    if (rst) begin
      match.source_prefix    <= RST_SOURCE_PREFIX;
      match.source_mask      <= RST_SOURCE_MASK;
      match.drop_port        <= RST_DROP_PORT;
      match.ipv6_dest_prefix <= RST_IPV6_DEST_PREFIX;
      socket_bound           <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SOURCE_PREFIX:     match.source_prefix    <= cfg_data[31:0];
        CFG_SOURCE_MASK:       match.source_mask      <= cfg_data[31:0];
        CFG_DROP_PORT:         match.drop_port        <= cfg_data[15:0];
        CFG_IPV6_DEST_PREFIX:  match.ipv6_dest_prefix <= cfg_data[15:0];
        CFG_SOCKET_BOUND_MASK: socket_bound           <= cfg_data[NUM_QUEUES-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/upf_parser.sv
// ----------------------------------------------------------------------------
// upf_parser
// Per-frame header capture and the verdict formed on the last byte.
// ----------------------------------------------------------------------------
module upf_parser
  import upf_pkg::*;
#(
  parameter int unsigned MAX_VLAN_TAGS = 2,
  parameter int unsigned NUM_QUEUES    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  upf_in_t               word,
  input  upf_match_t            match,
  input  logic [NUM_QUEUES-1:0] socket_bound,
  output upf_out_t              result
);

  logic [6:0]  byte_position;
  logic [15:0] ether_type;
  logic [4:0]  l3_offset;
  logic [7:0]  ip_protocol;
  logic [31:0] captured_source;
  logic [15:0] udp_port_seen;
  logic [15:0] ipv6_prefix_seen;
  logic [7:0]  tag_high;
  logic [31:0] frame_count;

  logic [15:0] ether_type_next;
  logic [4:0]  l3_offset_next;
  logic [7:0]  ip_protocol_next;
  logic [31:0] captured_source_next;
  logic [15:0] udp_port_seen_next;
  logic [15:0] ipv6_prefix_seen_next;
  logic [7:0]  tag_high_next;
  logic [31:0] frame_count_next;

  logic [7:0]             pos;
  logic [7:0]             off;
  logic [7:0]             off_next;
  logic [7:0]             frame_len;
  logic [7:0]             b;
  logic [QUEUE_SPACE-1:0] bound_ext;
  logic                   bound;
  logic                   drop;
  logic                   count;

  // A tag is still being skipped while the type says tag and the tag budget is left.
  function automatic logic vlan_open(input logic [15:0] et, input logic [4:0] ofs);
    logic [4:0] span;
    span = ofs - ETH_HDR_LEN[4:0];
    return ((et == ETH_TYPE_VLAN) || (et == ETH_TYPE_QINQ)) &&
           (span[4:2] < 3'(MAX_VLAN_TAGS));
  endfunction

  assign pos       = {1'b0, byte_position};
  assign off       = {3'b000, l3_offset};
  assign b         = word.data_byte;
  assign bound_ext = QUEUE_SPACE'(socket_bound);
  assign bound     = bound_ext[word.queue_index] &&
                     ({1'b0, word.queue_index} < 7'(NUM_QUEUES));

  // Capture of the current byte.
  always_comb begin
    ether_type_next       = ether_type;
    l3_offset_next        = l3_offset;
    ip_protocol_next      = ip_protocol;
    captured_source_next  = captured_source;
    udp_port_seen_next    = udp_port_seen;
    ipv6_prefix_seen_next = ipv6_prefix_seen;
    tag_high_next         = tag_high;
    if (pos == ETH_TYPE_HI_POS) begin
      ether_type_next = {b, 8'h00};
    end else if (pos == ETH_TYPE_LO_POS) begin
      ether_type_next = {ether_type[15:8], b};
      l3_offset_next  = ETH_HDR_LEN[4:0];
    end else if (pos >= ETH_HDR_LEN) begin
      if (vlan_open(ether_type, l3_offset)) begin
        if (pos == off + TAG_TYPE_HI_OFS) begin
          tag_high_next = b;
        end else if (pos == off + TAG_TYPE_LO_OFS) begin
          ether_type_next = {tag_high, b};
          l3_offset_next  = l3_offset + TAG_LEN;
        end
      end else if (ether_type == ETH_TYPE_IPV4) begin
        if (pos == off + IPV4_PROTO_OFS) begin
          ip_protocol_next = b;
        end else if (pos >= off + IPV4_SRC_FIRST && pos <= off + IPV4_SRC_LAST) begin
          captured_source_next = {captured_source[23:0], b};
        end else if (pos == off + IPV4_DPORT_HI || pos == off + IPV4_DPORT_LO) begin
          udp_port_seen_next = {udp_port_seen[7:0], b};
        end
      end else if (ether_type == ETH_TYPE_IPV6) begin
        if (pos == off + IPV6_NEXT_OFS) begin
          ip_protocol_next = b;
        end else if (pos == off + IPV6_DST_HI || pos == off + IPV6_DST_LO) begin
          ipv6_prefix_seen_next = {ipv6_prefix_seen[7:0], b};
        end else if (pos == off + IPV6_DPORT_HI || pos == off + IPV6_DPORT_LO) begin
          udp_port_seen_next = {udp_port_seen[7:0], b};
        end
      end
    end
  end

  // Verdict, formed from the state that includes the current byte.
  assign off_next  = {3'b000, l3_offset_next};
  assign frame_len = pos + 8'd1;

  always_comb begin
    result.action       = ACT_PASS;
    result.out_queue    = word.queue_index;
    result.last_source  = '0;
    count               = 1'b1;
    drop                = 1'b0;
    if (frame_len < ETH_HDR_LEN || vlan_open(ether_type_next, l3_offset_next)) begin
      result.action = ACT_PASS;
    end else if (ether_type_next == ETH_TYPE_IPV4 && frame_len < off_next + IPV4_MIN_LEN) begin
      result.action = ACT_PASS;
    end else if (ether_type_next == ETH_TYPE_IPV6 && frame_len < off_next + IPV6_MIN_LEN) begin
      // A cut-short IPv6 frame passes but is not counted.
      count = 1'b0;
    end else begin
      if (ether_type_next == ETH_TYPE_IPV4) begin
        result.last_source = captured_source_next;
        drop = (ip_protocol_next == IP_PROTO_UDP) &&
               ((captured_source_next & match.source_mask) == match.source_prefix) &&
               (udp_port_seen_next == match.drop_port);
      end else if (ether_type_next == ETH_TYPE_IPV6) begin
        drop = (ip_protocol_next == IP_PROTO_UDP) &&
               (ipv6_prefix_seen_next == match.ipv6_dest_prefix) &&
               (udp_port_seen_next == match.drop_port);
      end
      if (drop) begin
        result.action = ACT_DROP;
        count         = 1'b0;
      end else if (bound) begin
        result.action = ACT_REDIRECT;
      end
    end
    frame_count_next    = count ? frame_count + 32'd1 : frame_count;
    result.passed_count = frame_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      ether_type       <= '0;
      l3_offset        <= ETH_HDR_LEN[4:0];
      ip_protocol      <= '0;
      captured_source  <= '0;
      udp_port_seen    <= '0;
      ipv6_prefix_seen <= '0;
      tag_high         <= '0;
      frame_count      <= '0;
    end else if (take) begin
      if (word.last_byte) begin
        byte_position    <= '0;
        ether_type       <= '0;
        l3_offset        <= ETH_HDR_LEN[4:0];
        ip_protocol      <= '0;
        captured_source  <= '0;
        udp_port_seen    <= '0;
        ipv6_prefix_seen <= '0;
        tag_high         <= '0;
        frame_count      <= frame_count_next;
      end else begin
        if (!(&byte_position)) begin
          byte_position <= byte_position + 7'd1;
        end
        ether_type       <= ether_type_next;
        l3_offset        <= l3_offset_next;
        ip_protocol      <= ip_protocol_next;
        captured_source  <= captured_source_next;
        udp_port_seen    <= udp_port_seen_next;
        ipv6_prefix_seen <= ipv6_prefix_seen_next;
        tag_high         <= tag_high_next;
      end
    end
  end

endmodule

FILE: sv/udp_packet_filter_top.sv
// ----------------------------------------------------------------------------
// udp_packet_filter_top
// Byte-serial Ethernet/VLAN/IPv4/IPv6 UDP drop filter with socket redirect.
// ----------------------------------------------------------------------------
// Usage:
//   Frames enter on the frame channel one byte per word, in wire order, with
//   last_byte set on the final byte and queue_index held for the whole frame.
//   A word is taken at a rising edge where frame_valid is high and frame_stall
//   is low. Every word but the last updates the header capture registers and
//   gives no result. The last word of a frame gives exactly one result word on
//   the result channel: the action, the queue, the IPv4 source and the count
//   of frames that were neither dropped nor cut-short IPv6 frames.
//   Path: a last byte passes the input register and then the result register
//   before its result shows on the result channel.
//   Throughput: one byte per cycle while no last byte waits, set by the single
//   parse stage between the input register and the result register.
//   When the receiver stalls, the result register holds its word. Bytes that
//   are not the last of a frame keep flowing; a last byte waits in the input
//   register until the result register frees, and frame_stall is raised to
//   the sender for as long as it waits.
//   Reset clears both registers, the frame capture state and the counter, and
//   loads the match registers with their defaults. The user makes configuration
//   writes only while no frame is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module udp_packet_filter_top
  import upf_pkg::*;
#(
  parameter int unsigned MAX_VLAN_TAGS = 2,
  parameter int unsigned NUM_QUEUES    = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  output logic                   frame_stall,
  input  upf_in_t                frame_word,
  output logic                   result_valid,
  input  logic                   result_stall,
  output upf_out_t               result_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  upf_match_t            match;
  logic [NUM_QUEUES-1:0] socket_bound;
  upf_out_t              verdict;

  // Input register.
  logic    hold_valid;
  upf_in_t hold_word;
  logic    hold_blocked;
  logic    take;

  // Only a last byte needs the result register, so only it can be held up.
  assign hold_blocked = hold_word.last_byte && result_valid && result_stall;
  assign take         = hold_valid && !hold_blocked;
  assign frame_stall  = hold_valid && hold_blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (frame_valid && !frame_stall) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      hold_word <= frame_word;
    end
  end

  upf_cfg_regs #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .match        (match),
    .socket_bound (socket_bound)
  );

  upf_parser #(
    .MAX_VLAN_TAGS (MAX_VLAN_TAGS),
    .NUM_QUEUES    (NUM_QUEUES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .word         (hold_word),
    .match        (match),
    .socket_bound (socket_bound),
    .result       (verdict)
  );

  // Result register. A new verdict is loaded only when the slot is empty or
  // its word is being taken in this same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && hold_word.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold_word.last_byte) begin
      result_word <= verdict;
    end
  end

endmodule

FILE: sv/upf_checker.sv
// ----------------------------------------------------------------------------
// upf_checker
// Port-level checks of the packet filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "udp_packet_filter_top_defines.svh"

module upf_checker
  import upf_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     frame_valid,
  input logic     frame_stall,
  input upf_in_t  frame_word,
  input logic     result_valid,
  input logic     result_stall,
  input upf_out_t result_word
);

  // A stalled result holds until taken.
  `UPF_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                   result_valid && $stable(result_word), "stalled result changed")

  // Only the three defined actions appear.
  `UPF_ASSERT_SAME(a_action_code, result_valid,
                   result_word.action == ACT_PASS || result_word.action == ACT_DROP ||
                   result_word.action == ACT_REDIRECT, "undefined action code")

  // A fresh result follows a last byte taken on the frame channel.
  `UPF_ASSERT_SAME(a_result_source, $rose(result_valid),
                   $past(frame_valid && !frame_stall && frame_word.last_byte, 2),
                   "result without a last byte")

  // Reset leaves no result pending and the input open.
  `UPF_ASSERT_ALWAYS(a_reset_clear, rst, !result_valid && !frame_stall,
                     "state left after reset")

endmodule

bind udp_packet_filter_top upf_checker u_upf_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .frame_word   (frame_word),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);

FILE: tb/upf_result_checker.sv
// ----------------------------------------------------------------------------
// upf_result_checker
// Watches the frame, result and register ports of the packet filter. It keeps
// its own copy of the header parse and the registers, works out the verdict
// that each last byte of a frame must give, and compares every result word
// with the oldest verdict still owed.
// ----------------------------------------------------------------------------
module upf_result_checker
  import upf_pkg::*;
#(
  parameter int unsigned MAX_VLAN_TAGS = 2,
  parameter int unsigned NUM_QUEUES    = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  input  logic                   frame_stall,
  input  upf_in_t                frame_word,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  upf_out_t               result_word,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     error_total,
  output int                     results_owed
);

  // Shadow copy of the match registers.
  logic [31:0] prefix_reg;
  logic [31:0] mask_reg;
  logic [15:0] port_reg;
  logic [15:0] v6_prefix_reg;
  logic [63:0] bound_reg;

  // Shadow copy of the per-frame header capture.
  logic [6:0]  hdr_pos;
  logic [15:0] eth_type;
  logic [4:0]  l3_start;
  logic [7:0]  l4_proto;
  logic [31:0] v4_source;
  logic [15:0] dport_seen;
  logic [15:0] v6_dest_hi;
  logic [7:0]  tag_type_hi;
  logic [31:0] passed_total;

  upf_out_t verdict_q[$];
  upf_out_t owed;
  int       errors;

  assign error_total = errors;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
    errors++;
  endtask

  function automatic bit tag_pending();
    int tags;
    tags = (int'(l3_start) - int'(ETH_HDR_LEN)) / int'(TAG_LEN);
    return (eth_type == ETH_TYPE_VLAN || eth_type == ETH_TYPE_QINQ) &&
           tags < int'(MAX_VLAN_TAGS);
  endfunction

  task automatic clear_capture();
    hdr_pos     = '0;
    eth_type    = '0;
    l3_start    = 5'(ETH_HDR_LEN);
    l4_proto    = '0;
    v4_source   = '0;
    dport_seen  = '0;
    v6_dest_hi  = '0;
    tag_type_hi = '0;
  endtask

  // Folds one frame byte into the capture state and, on the last byte,
  // queues the verdict that the frame must produce.
  task automatic classify_byte(input upf_in_t w);
    int          p;
    int          off;
    int          len;
    logic [1:0]  act;
    logic [31:0] src;
    bit          counted;
    bit          drop;
    logic [7:0]  b;
    b   = w.data_byte;
    p   = int'(hdr_pos);
    off = int'(l3_start);
    if (p == ETH_TYPE_HI_POS) begin
      eth_type = {b, 8'h00};
    end else if (p == ETH_TYPE_LO_POS) begin
      eth_type[7:0] = b;
      l3_start      = 5'(ETH_HDR_LEN);
    end else if (p >= ETH_HDR_LEN) begin
      if (tag_pending()) begin
        if (p == off + TAG_TYPE_HI_OFS) begin
          tag_type_hi = b;
        end else if (p == off + TAG_TYPE_LO_OFS) begin
          eth_type = {tag_type_hi, b};
          l3_start = 5'(off + int'(TAG_LEN));
        end
      end else if (eth_type == ETH_TYPE_IPV4) begin
        if (p == off + IPV4_PROTO_OFS) begin
          l4_proto = b;
        end else if (p >= off + IPV4_SRC_FIRST && p <= off + IPV4_SRC_LAST) begin
          v4_source = {v4_source[23:0], b};
        end else if (p == off + IPV4_DPORT_HI || p == off + IPV4_DPORT_LO) begin
          dport_seen = {dport_seen[7:0], b};
        end
      end else if (eth_type == ETH_TYPE_IPV6) begin
        if (p == off + IPV6_NEXT_OFS) begin
          l4_proto = b;
        end else if (p == off + IPV6_DST_HI || p == off + IPV6_DST_LO) begin
          v6_dest_hi = {v6_dest_hi[7:0], b};
        end else if (p == off + IPV6_DPORT_HI || p == off + IPV6_DPORT_LO) begin
          dport_seen = {dport_seen[7:0], b};
        end
      end
    end
    if (hdr_pos != 7'd127) begin
      hdr_pos = hdr_pos + 7'd1;
    end
    if (w.last_byte) begin
      len     = p + 1;
      off     = int'(l3_start);
      act     = ACT_PASS;
      src     = '0;
      counted = 1'b1;
      if (len < ETH_HDR_LEN || tag_pending()) begin
        act = ACT_PASS;
      end else if (eth_type == ETH_TYPE_IPV4 && len < off + IPV4_MIN_LEN) begin
        act = ACT_PASS;
      end else if (eth_type == ETH_TYPE_IPV6 && len < off + IPV6_MIN_LEN) begin
        // A cut-short IPv6 frame passes but is left out of the count.
        act     = ACT_PASS;
        counted = 1'b0;
      end else begin
        drop = 1'b0;
        if (eth_type == ETH_TYPE_IPV4) begin
          src  = v4_source;
          drop = l4_proto == IP_PROTO_UDP && (src & mask_reg) == prefix_reg &&
                 dport_seen == port_reg;
        end else if (eth_type == ETH_TYPE_IPV6) begin
          drop = l4_proto == IP_PROTO_UDP && v6_dest_hi == v6_prefix_reg &&
                 dport_seen == port_reg;
        end
        if (drop) begin
          act     = ACT_DROP;
          counted = 1'b0;
        end else if (int'(w.queue_index) < int'(NUM_QUEUES) &&
                     bound_reg[w.queue_index]) begin
          act = ACT_REDIRECT;
        end
      end
      if (counted) begin
        passed_total = passed_total + 32'd1;
      end
      verdict_q.push_back('{action: act, out_queue: w.queue_index,
                            last_source: src, passed_count: passed_total});
      clear_capture();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      prefix_reg    = RST_SOURCE_PREFIX;
      mask_reg      = RST_SOURCE_MASK;
      port_reg      = RST_DROP_PORT;
      v6_prefix_reg = RST_IPV6_DEST_PREFIX;
      bound_reg     = '0;
      passed_total  = '0;
      errors        = 0;
      clear_capture();
      verdict_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unrequested result, passed_count", '0,
                          result_word.passed_count);
        end else begin
          owed = verdict_q.pop_front();
          if (result_word.action !== owed.action)
            report_mismatch("action", owed.action, result_word.action);
          if (result_word.out_queue !== owed.out_queue)
            report_mismatch("out_queue", owed.out_queue, result_word.out_queue);
          if (result_word.last_source !== owed.last_source)
            report_mismatch("last_source", owed.last_source, result_word.last_source);
          if (result_word.passed_count !== owed.passed_count)
            report_mismatch("passed_count", owed.passed_count,
                            result_word.passed_count);
        end
      end
      if (frame_valid && !frame_stall) begin
        classify_byte(frame_word);
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SOURCE_PREFIX: begin
            prefix_reg = cfg_data[31:0];
          end
          CFG_SOURCE_MASK: begin
            mask_reg = cfg_data[31:0];
          end
          CFG_DROP_PORT: begin
            port_reg = cfg_data[15:0];
          end
          CFG_IPV6_DEST_PREFIX: begin
            v6_prefix_reg = cfg_data[15:0];
          end
          CFG_SOCKET_BOUND_MASK: begin
            bound_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
    results_owed <= verdict_q.size();
  end

endmodule

FILE: tb/udp_packet_filter_top_test.sv
// ----------------------------------------------------------------------------
// udp_packet_filter_top_test
// Drives Ethernet frames byte by byte into the packet filter under several
// register settings and idle patterns. A checker beside the block predicts
// every result word; this module makes the traffic and gives the verdict.
// ----------------------------------------------------------------------------
module udp_packet_filter_top_test;
  import upf_pkg::*;

  localparam int unsigned TAG_LIMIT   = 2;
  localparam int unsigned QUEUES      = 64;
  localparam int          CYCLE_LIMIT = 200000;

  // Codes that are not in the package but that the traffic needs.
  localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
  localparam logic [15:0] ETH_TYPE_LLDP = 16'h88CC;

  typedef enum int {L3_IPV4, L3_IPV6, L3_OTHER} l3_kind_e;

  logic                   clk;
  logic                   rst;
  logic                   frame_valid;
  logic                   frame_stall;
  upf_in_t                frame_word;
  logic                   result_valid;
  logic                   result_stall;
  upf_out_t               result_word;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int error_total;
  int results_owed;

  // Idle rates in percent, and a long receiver hold-off counted down by the
  // receiver process.
  int send_idle_pct;
  int recv_stall_pct;
  int recv_hold;
  int cycle_count;

  int words_sent;
  int frames_sent;

  // Bytes of the frame being built, and the register values in force, which
  // the frame builder uses to aim at the drop rules.
  logic [7:0]  frame_bytes[$];
  logic [31:0] cur_prefix;
  logic [31:0] cur_mask;
  logic [15:0] cur_port;
  logic [15:0] cur_v6;

  udp_packet_filter_top #(
    .MAX_VLAN_TAGS(TAG_LIMIT),
    .NUM_QUEUES   (QUEUES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word (result_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  upf_result_checker #(
    .MAX_VLAN_TAGS(TAG_LIMIT),
    .NUM_QUEUES   (QUEUES)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_word  (frame_word),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_word (result_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_total (error_total),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off if it hangs; a stuck handshake or a result that never
  // comes ends up here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // The receiver stalls at random, except while a hold-off is counting down,
  // when it stalls every cycle.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold > 0) begin
        result_stall <= 1'b1;
        recv_hold--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // One frame byte is offered as one word, after a random number of idle
  // cycles, and held until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic last, input logic [5:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_word  <= '{data_byte: b, last_byte: last, queue_index: q};
    do @(posedge clk); while (frame_stall);
    words_sent++;
  endtask

  task automatic send_frame(input logic [5:0] q);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_word(frame_bytes[i], i == frame_bytes.size() - 1, q);
    end
    frames_sent++;
  endtask

  // The sender goes quiet until every owed result has been taken, then
  // leaves the result path time to settle.
  task automatic drain();
    frame_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_fill(input logic [7:0] v, input int n);
    repeat (n) frame_bytes.push_back(v);
  endtask

  task automatic add16(input logic [15:0] v);
    frame_bytes.push_back(v[15:8]);
    frame_bytes.push_back(v[7:0]);
  endtask

  // Builds a frame: MAC addresses, ntags VLAN tags, then the layer 3 part.
  // The hit flags choose whether the protocol, source, destination prefix
  // and port agree with the current drop rules. A nonzero cut truncates the
  // frame to at most that many bytes.
  task automatic make_frame(input int ntags, input l3_kind_e kind, input bit udp,
                            input bit hit_src, input bit hit_port, input bit hit_v6,
                            input int extra, input int cut);
    logic [15:0] et;
    logic [31:0] src;
    logic [7:0]  proto;
    frame_bytes.delete();
    add_random(12);
    for (int i = 0; i < ntags; i++) begin
      add16($urandom_range(1) ? ETH_TYPE_VLAN : ETH_TYPE_QINQ);
      add_random(2);
    end
    proto = udp ? IP_PROTO_UDP : 8'($urandom_range(255));
    if (!udp && proto == IP_PROTO_UDP) begin
      proto = IP_PROTO_TCP;
    end
    case (kind)
      L3_IPV4: begin
        src = hit_src ? ((cur_prefix & cur_mask) | ($urandom & ~cur_mask)) : $urandom;
        add16(ETH_TYPE_IPV4);
        frame_bytes.push_back(8'h45);
        add_random(8);
        frame_bytes.push_back(proto);
        add_random(2);
        add16(src[31:16]);
        add16(src[15:0]);
        add_random(4 + 2);
        add16(hit_port ? cur_port : 16'($urandom_range(65535)));
        add_random(4);
      end
      L3_IPV6: begin
        add16(ETH_TYPE_IPV6);
        frame_bytes.push_back(8'h60);
        add_random(5);
        frame_bytes.push_back(proto);
        add_random(17);
        add16(hit_v6 ? cur_v6 : 16'($urandom_range(65535)));
        add_random(14 + 2);
        add16(hit_port ? cur_port : 16'($urandom_range(65535)));
        add_random(4);
      end
      default: begin
        et = 16'($urandom_range(65535));
        if (et == ETH_TYPE_IPV4 || et == ETH_TYPE_IPV6 ||
            et == ETH_TYPE_VLAN || et == ETH_TYPE_QINQ) begin
          et = ETH_TYPE_LLDP;
        end
        add16(et);
        add_random(20);
      end
    endcase
    add_random(extra);
    if (cut > 0) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endtask

  // Most random frames are well-formed headers with random content, aimed
  // at the drop rules more often than not; some are cut short at a random
  // point, and a tenth are plain noise.
  task automatic random_frame();
    int       r;
    int       ntags;
    l3_kind_e kind;
    r = $urandom_range(99);
    if (r < 10) begin
      frame_bytes.delete();
      add_random($urandom_range(1, 40));
    end else begin
      r = $urandom_range(19);
      ntags = (r < 10) ? 0 : (r < 15) ? 1 : (r < 19) ? 2 : 3;
      r = $urandom_range(19);
      if (r < 9) begin
        kind = L3_IPV4;
      end else if (r < 17) begin
        kind = L3_IPV6;
      end else begin
        kind = L3_OTHER;
      end
      make_frame(ntags, kind, $urandom_range(9) != 0, $urandom_range(9) < 6,
                 $urandom_range(9) < 6, $urandom_range(9) < 6, $urandom_range(6),
                 ($urandom_range(4) == 0) ? $urandom_range(1, 60) : 0);
    end
    send_frame(6'($urandom_range(63)));
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int words);
    int first_word;
    int first_frame;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    first_word     = words_sent;
    first_frame    = frames_sent;
    while (words_sent - first_word < words || frames_sent - first_frame < 20) begin
      random_frame();
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Register writes happen only once the block has gone idle.
  task automatic write_rules(input logic [31:0] prefix, input logic [31:0] mask,
                             input logic [15:0] port, input logic [15:0] v6,
                             input logic [63:0] bound);
    drain();
    write_reg(CFG_SOURCE_PREFIX, 64'(prefix));
    write_reg(CFG_SOURCE_MASK, 64'(mask));
    write_reg(CFG_DROP_PORT, 64'(port));
    write_reg(CFG_IPV6_DEST_PREFIX, 64'(v6));
    write_reg(CFG_SOCKET_BOUND_MASK, bound);
    cfg_write  <= 1'b0;
    cur_prefix = prefix;
    cur_mask   = mask;
    cur_port   = port;
    cur_v6     = v6;
  endtask

  initial begin
    rst            <= 1'b1;
    frame_valid    <= 1'b0;
    frame_word     <= '0;
    cfg_write      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    recv_hold      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    words_sent     = 0;
    frames_sent    = 0;
    cur_prefix     = RST_SOURCE_PREFIX;
    cur_mask       = RST_SOURCE_MASK;
    cur_port       = RST_DROP_PORT;
    cur_v6         = RST_IPV6_DEST_PREFIX;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frames run on the reset values of the registers, so the
    // drop rules of the defaults are exercised before anything is written.
    send_idle_pct  = 20;
    recv_stall_pct = 50;
    frame_bytes.delete();
    add_random(1);
    send_frame(6'd0);                                   // single-byte frame
    frame_bytes.delete();
    add_fill(8'hFF, 13);
    send_frame(6'd63);                                  // one byte short of a header
    make_frame(0, L3_IPV4, 1, 1, 1, 1, 0, 0);
    send_frame(6'd5);                                   // IPv4 drop at minimum length
    make_frame(0, L3_IPV4, 0, 1, 1, 1, 0, 0);
    send_frame(6'd6);                                   // not UDP
    make_frame(0, L3_IPV4, 1, 0, 1, 1, 0, 0);
    send_frame(6'd7);                                   // source outside the prefix
    make_frame(0, L3_IPV4, 1, 1, 0, 1, 2, 0);
    send_frame(6'd8);                                   // other port
    make_frame(0, L3_IPV4, 1, 1, 1, 1, 0, 41);
    send_frame(6'd9);                                   // IPv4 one byte short of UDP
    make_frame(0, L3_IPV6, 1, 1, 1, 1, 0, 0);
    send_frame(6'd10);                                  // IPv6 drop at minimum length
    make_frame(0, L3_IPV6, 1, 1, 1, 1, 0, 61);
    send_frame(6'd11);                                  // IPv6 cut short, not counted
    make_frame(0, L3_IPV6, 1, 1, 1, 0, 3, 0);
    send_frame(6'd12);                                  // other IPv6 destination
    make_frame(1, L3_IPV4, 1, 1, 1, 1, 0, 0);
    send_frame(6'd13);                                  // one tag, dropped
    make_frame(2, L3_IPV6, 1, 1, 1, 1, 0, 0);
    send_frame(6'd14);                                  // two tags, dropped
    make_frame(1, L3_IPV4, 1, 1, 1, 1, 0, 16);
    send_frame(6'd15);                                  // ends inside a tag
    make_frame(3, L3_IPV4, 1, 1, 1, 1, 0, 0);
    send_frame(6'd16);                                  // one tag too many
    make_frame(0, L3_OTHER, 1, 1, 1, 1, 0, 0);
    send_frame(6'd17);                                  // unknown ether type
    make_frame(0, L3_IPV4, 1, 1, 1, 1, 100, 0);
    send_frame(6'd42);                                  // long enough to saturate position
    frame_bytes.delete();
    add_fill(8'h00, 20);
    send_frame(6'd21);                                  // all-zero frame

    // Random rules with some sockets bound; sender idles lightly, receiver
    // heavily.
    write_rules($urandom, 32'hFFFF_0000, 16'($urandom_range(65535)),
                16'($urandom_range(65535)), {$urandom, $urandom});
    run_phase(20, 50, 310);

    // Lowest values: every source matches, port and prefix zero, every
    // queue bound. Sender idles heavily, receiver lightly.
    write_rules('0, '0, '0, '0, '1);
    run_phase(50, 20, 310);

    // Highest values and no sockets bound; no idling at all.
    write_rules('1, '1, 16'hFFFF, 16'hFFFF, '0);
    run_phase(0, 0, 330);

    // The receiver holds off for a long stretch while short frames keep
    // coming, so the result register and then the input fill and the block
    // stalls its sender. Afterwards the sender waits for every result.
    recv_hold = 300;
    repeat (12) begin
      frame_bytes.delete();
      add_random($urandom_range(1, 4));
      send_frame(6'($urandom_range(63)));
    end
    drain();

    if (error_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
